/* design/ppmfe_pkg.sv */
// ppm frame encoder package: constants, register codes, shared types
`timescale 1ns / 1ps

package ppmfe_pkg;

   // default module parameters
   localparam int MAX_CHANNELS_DEF     = 32;
   localparam int EXTENDED_PERCENT_DEF = 150;

   // timing constants in 2 MHz ticks
   localparam int BASE_TICKS    = 45000;
   localparam int ADJ_UNIT      = 1000;
   localparam int SYNC_MIN      = 9000;
   localparam int DUR_MAX       = 32767;
   localparam int TERM_TICKS    = 1000;
   localparam int NOMINAL_RANGE = 1024;
   localparam int HALF_RANGE    = 512;

   // running remainder width, covers up to 64 channels of either sign
   localparam int REM_W = 22;

   // field widths
   localparam int VALUE_W  = 16;
   localparam int CENTER_W = 12;
   localparam int DUR_W    = 15;
   localparam int KIND_W   = 2;
   localparam int ADDR_W   = 3;
   localparam int WDATA_W  = 15;

   // register indexes
   localparam logic [ADDR_W-1:0] REG_ENABLED  = 3'd0;
   localparam logic [ADDR_W-1:0] REG_POLARITY = 3'd1;
   localparam logic [ADDR_W-1:0] REG_STOP     = 3'd2;
   localparam logic [ADDR_W-1:0] REG_EXTENDED = 3'd3;
   localparam logic [ADDR_W-1:0] REG_ADJ      = 3'd4;
   localparam logic [ADDR_W-1:0] REG_COUNT    = 3'd5;
   localparam logic [ADDR_W-1:0] REG_FIRST    = 3'd6;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_PULSE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SYNC  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TERM  = 2'd2;

   // register reset values
   localparam logic [DUR_W-1:0] STOP_RESET  = 15'd600;
   localparam logic [5:0]       COUNT_RESET = 6'd8;

   typedef struct packed {
      logic              enabled;
      logic              polarity;
      logic [DUR_W-1:0]  stop_width;
      logic              extended_limits;
      logic signed [7:0] frame_length_adj;
      logic [5:0]        channels_in_frame;
      logic [4:0]        first_channel;
   } cfg_type;

   typedef struct packed {
      logic [DUR_W-1:0]  first_duration;
      logic              first_level;
      logic [DUR_W-1:0]  second_duration;
      logic              second_level;
      logic [KIND_W-1:0] item_kind;
      logic              frame_end;
   } result_type;

   typedef struct packed {
      logic              done;       // last result of the current input item
      logic              step_pulse; // store new remainder, advance channel
      logic              step_sync;  // frame closes, channel back to zero
      logic [KIND_W-1:0] next_kind;
   } ctrl_type;

endpackage

/* design/ppmfe_csr.sv */
// configuration registers of the ppm frame encoder
`timescale 1ns / 1ps

module ppmfe_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ppmfe_pkg::ADDR_W-1:0]   csr_addr,
   input  logic [ppmfe_pkg::WDATA_W-1:0]  csr_wdata,
   output ppmfe_pkg::cfg_type             cfg
);
   import ppmfe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_ENABLED:  cfg_in.enabled           = csr_wdata[0];
            REG_POLARITY: cfg_in.polarity          = csr_wdata[0];
            REG_STOP:     cfg_in.stop_width        = csr_wdata[DUR_W-1:0];
            REG_EXTENDED: cfg_in.extended_limits   = csr_wdata[0];
            REG_ADJ:      cfg_in.frame_length_adj  = $signed(csr_wdata[7:0]);
            REG_COUNT:    cfg_in.channels_in_frame = csr_wdata[5:0];
            REG_FIRST:    cfg_in.first_channel     = csr_wdata[4:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled           <= 1'b1;
         cfg_ff.polarity          <= 1'b0;
         cfg_ff.stop_width        <= STOP_RESET;
         cfg_ff.extended_limits   <= 1'b0;
         cfg_ff.frame_length_adj  <= 8'sd0;
         cfg_ff.channels_in_frame <= COUNT_RESET;
         cfg_ff.first_channel     <= 5'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/ppmfe_calc.sv */
// result computation for one step of the ppm frame encoder
`timescale 1ns / 1ps

module ppmfe_calc #(
   parameter int MAX_CHANNELS     = ppmfe_pkg::MAX_CHANNELS_DEF,
   parameter int EXTENDED_PERCENT = ppmfe_pkg::EXTENDED_PERCENT_DEF,
   parameter int IDX_W            = $clog2(MAX_CHANNELS + 1)
) (
   input  ppmfe_pkg::cfg_type                     cfg,
   input  logic signed [ppmfe_pkg::VALUE_W-1:0]   channel_value,
   input  logic [ppmfe_pkg::CENTER_W-1:0]         center_us,
   input  logic                                   mid,
   input  logic [ppmfe_pkg::KIND_W-1:0]           kind,
   input  logic signed [ppmfe_pkg::REM_W-1:0]     rem,
   input  logic [IDX_W-1:0]                       idx,
   output ppmfe_pkg::result_type                  result,
   output ppmfe_pkg::ctrl_type                    ctrl,
   output logic signed [ppmfe_pkg::REM_W-1:0]     rem_next
);
   import ppmfe_pkg::*;

   localparam int EXT_RANGE = (HALF_RANGE * EXTENDED_PERCENT / 100) * 2;

   logic [7:0]                last_sum;
   logic [7:0]                last_lim;
   logic [7:0]                nch_wide;
   logic [IDX_W-1:0]          nch;
   logic                      last_channel;
   logic [KIND_W-1:0]         cur_kind;
   logic signed [VALUE_W-1:0] range_pos;
   logic signed [VALUE_W-1:0] range_neg;
   logic signed [VALUE_W-1:0] val_c;
   logic signed [VALUE_W-1:0] width;
   logic signed [VALUE_W:0]   idle_raw;
   logic [DUR_W-1:0]          idle_dur;
   logic signed [REM_W-1:0]   adj_x;
   logic signed [REM_W-1:0]   base;
   logic signed [REM_W-1:0]   rem0;
   logic [DUR_W-1:0]          rest;
   logic                      pulse_lv;
   logic                      idle_lv;

   // channel count of the frame, limited by the channel maximum
   assign last_sum = 8'(cfg.first_channel) + 8'(cfg.channels_in_frame);
   assign last_lim = (last_sum > 8'(MAX_CHANNELS)) ? 8'(MAX_CHANNELS) : last_sum;
   assign nch_wide = (last_lim > 8'(cfg.first_channel)) ?
                     (last_lim - 8'(cfg.first_channel)) : 8'd0;
   assign nch      = IDX_W'(nch_wide);
   assign last_channel = ((IDX_W+1)'(idx) + (IDX_W+1)'(1)) >= (IDX_W+1)'(nch);

   // frame remainder, reloaded at the first channel
   assign adj_x = REM_W'(cfg.frame_length_adj);
   assign base  = $signed(REM_W'(BASE_TICKS)) + adj_x * $signed(REM_W'(ADJ_UNIT));
   assign rem0  = (idx == '0) ? base : rem;

   // clamp the channel value and add the doubled center
   assign range_pos = cfg.extended_limits ? $signed(VALUE_W'(EXT_RANGE))
                                          : $signed(VALUE_W'(NOMINAL_RANGE));
   assign range_neg = -range_pos;
   always_comb begin
      priority if (channel_value > range_pos) val_c = range_pos;
      else if (channel_value < range_neg)     val_c = range_neg;
      else                                    val_c = channel_value;
   end
   assign width    = val_c + $signed({3'b000, center_us, 1'b0});
   assign rem_next = rem0 - REM_W'(width);

   // idle part of the pulse, saturated
   assign idle_raw = VALUE_W'(width) - $signed({2'b00, cfg.stop_width});
   always_comb begin
      priority if (idle_raw < 0)                   idle_dur = '0;
      else if (idle_raw > $signed((VALUE_W+1)'(DUR_MAX))) idle_dur = DUR_W'(DUR_MAX);
      else                                         idle_dur = idle_raw[DUR_W-1:0];
   end

   // sync gap from the remainder
   always_comb begin
      priority if (rem0 > $signed(REM_W'(DUR_MAX)))  rest = DUR_W'(DUR_MAX - TERM_TICKS);
      else if (rem0 < $signed(REM_W'(SYNC_MIN)))     rest = DUR_W'(SYNC_MIN - TERM_TICKS);
      else rest = rem0[DUR_W-1:0] - DUR_W'(TERM_TICKS);
   end

   assign pulse_lv = cfg.polarity;
   assign idle_lv  = ~cfg.polarity;
   assign cur_kind = mid ? kind : ((nch != '0) ? KIND_PULSE : KIND_SYNC);

   // result selection and step control
   always_comb begin
      result.first_duration  = cfg.stop_width;
      result.first_level     = pulse_lv;
      result.second_duration = idle_dur;
      result.second_level    = idle_lv;
      result.item_kind       = cur_kind;
      result.frame_end       = 1'b0;
      ctrl.done       = 1'b1;
      ctrl.step_pulse = 1'b0;
      ctrl.step_sync  = 1'b0;
      ctrl.next_kind  = KIND_SYNC;
      unique case (cur_kind)
         KIND_PULSE: begin
            ctrl.step_pulse = 1'b1;
            ctrl.done       = ~last_channel;
         end
         KIND_SYNC: begin
            result.second_duration = rest;
            ctrl.step_sync = 1'b1;
            ctrl.done      = 1'b0;
            ctrl.next_kind = KIND_TERM;
         end
         default: begin
            result.first_duration  = DUR_W'(TERM_TICKS);
            result.first_level     = idle_lv;
            result.second_duration = '0;
            result.item_kind       = KIND_TERM;
            result.frame_end       = 1'b1;
         end
      endcase
   end

endmodule

/* design/ppm_frame_encoder_top.sv */
// ppm frame encoder top level: input register, step sequencing, result register
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tdata: channel_value, center_us
//   rsp      out  rsp_tvalid/tready    tdata: durations and levels, tuser: kind,
//                                      tlast: frame end
//   csr      in   csr_we               csr_addr, csr_wdata
//
// A channel transaction that is not the last of the frame gives one result;
// the last channel gives pulse, sync and terminator. One result leaves the step
// logic per cycle into the result register while that register is empty or
// being read. A new transaction is taken in the cycle its predecessor gives its
// last result. With the encoder disabled a transaction is dropped. Reset is
// synchronous and resets frame state, valid flags and configuration registers.
`timescale 1ns / 1ps

module ppm_frame_encoder_top #(
   parameter int MAX_CHANNELS     = ppmfe_pkg::MAX_CHANNELS_DEF,
   parameter int EXTENDED_PERCENT = ppmfe_pkg::EXTENDED_PERCENT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [15:0] channel_value, [27:16] center_us, [31:28] zero
   input  logic [31:0]                   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [14:0] first_duration, [15] first_level, [30:16] second_duration,
   // [31] second_level
   output logic [31:0]                   rsp_tdata,
   // [1:0] item_kind
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [ppmfe_pkg::ADDR_W-1:0]  csr_addr,
   input  logic [ppmfe_pkg::WDATA_W-1:0] csr_wdata
);
   import ppmfe_pkg::*;

   localparam int IDX_W = $clog2(MAX_CHANNELS + 1);

   cfg_type                   cfg;
   result_type                result;
   ctrl_type                  ctrl;
   logic signed [REM_W-1:0]   rem_next;

   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic signed [VALUE_W-1:0] in_value_ff;
   logic [CENTER_W-1:0]       in_center_ff;
   logic                      mid_ff;
   logic                      mid_in;
   logic [KIND_W-1:0]         kind_ff;
   logic [KIND_W-1:0]         kind_in;
   logic signed [REM_W-1:0]   rem_ff;
   logic signed [REM_W-1:0]   rem_in;
   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W-1:0]          idx_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   result_type                rsp_ff;

   logic                      out_free;
   logic                      emit;
   logic                      item_done;
   logic                      req_take;

   ppmfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppmfe_calc #(
      .MAX_CHANNELS     (MAX_CHANNELS),
      .EXTENDED_PERCENT (EXTENDED_PERCENT),
      .IDX_W            (IDX_W)
   ) u_calc (
      .cfg           (cfg),
      .channel_value (in_value_ff),
      .center_us     (in_center_ff),
      .mid           (mid_ff),
      .kind          (kind_ff),
      .rem           (rem_ff),
      .idx           (idx_ff),
      .result        (result),
      .ctrl          (ctrl),
      .rem_next      (rem_next)
   );

   // handshake and step control
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign emit       = in_valid_ff & cfg.enabled & out_free;
   assign item_done  = in_valid_ff & (~cfg.enabled | (out_free & ctrl.done));
   assign req_tready = ~in_valid_ff | item_done;
   assign req_take   = req_tvalid & req_tready;

   // next values of the control state
   always_comb begin
      in_valid_in  = req_take | (in_valid_ff & ~item_done);
      mid_in       = mid_ff;
      kind_in      = kind_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      rsp_valid_in = emit | (rsp_valid_ff & ~rsp_tready);
      if (emit) begin
         mid_in  = ~ctrl.done;
         kind_in = ctrl.next_kind;
         if (ctrl.step_pulse) begin
            rem_in = rem_next;
            idx_in = idx_ff + IDX_W'(1);
         end
         if (ctrl.step_sync) begin
            idx_in = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_ff       <= 1'b0;
         kind_ff      <= KIND_PULSE;
         rem_ff       <= $signed(REM_W'(BASE_TICKS));
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_ff       <= mid_in;
         kind_ff      <= kind_in;
         rem_ff       <= rem_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_value_ff  <= $signed(req_tdata[VALUE_W-1:0]);
         in_center_ff <= req_tdata[VALUE_W+CENTER_W-1:VALUE_W];
      end
      if (emit) begin
         rsp_ff <= result;
      end
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.second_level, rsp_ff.second_duration,
                        rsp_ff.first_level, rsp_ff.first_duration};
   assign rsp_tuser  = rsp_ff.item_kind;
   assign rsp_tlast  = rsp_ff.frame_end;

endmodule

/* tb/tb.sv */
// ppm frame encoder testbench: directed and random channel streams against a frame predictor
`timescale 1ns / 1ps

module tb;
   import ppmfe_pkg::*;

   localparam int RUN_LIMIT   = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 8;
   localparam int END_WAIT    = 5000;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [31:0]        req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [31:0]        rsp_tdata;
   logic [1:0]         rsp_tuser;
   logic               rsp_tlast;
   logic               csr_we;
   logic [ADDR_W-1:0]  csr_addr;
   logic [WDATA_W-1:0] csr_wdata;

   ppm_frame_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the encoder registers and frame state
   cfg_type    shadow_cfg;
   int         frame_rest;
   int         chan_pos;
   result_type items_due[$];

   int error_count;
   int channels_sent;
   int results_seen;
   int frames_closed;
   int cycle_count;
   int send_idle_pct;
   int recv_stall_pct;
   int holds_asked;
   int holds_done;
   int hold_left;

   function automatic result_type make_item(int d0, bit l0, int d1, bit l1,
                                            logic [KIND_W-1:0] kind, bit fe);
      result_type r;
      r.first_duration  = d0[DUR_W-1:0];
      r.first_level     = l0;
      r.second_duration = d1[DUR_W-1:0];
      r.second_level    = l1;
      r.item_kind       = kind;
      r.frame_end       = fe;
      return r;
   endfunction

   // frame step: pulse for the channel, sync and terminator after the last one
   function automatic void predict_frame_step(logic signed [15:0] value,
                                              logic [11:0] center_us);
      int  first_ch;
      int  span_end;
      int  chans;
      int  adj;
      int  limit;
      int  clamped;
      int  width;
      int  rest;
      bit  pulse_lv;
      if (!shadow_cfg.enabled) return;
      pulse_lv = shadow_cfg.polarity;
      first_ch = int'(shadow_cfg.first_channel);
      span_end = first_ch + int'(shadow_cfg.channels_in_frame);
      if (span_end > MAX_CHANNELS_DEF) span_end = MAX_CHANNELS_DEF;
      chans = (span_end > first_ch) ? span_end - first_ch : 0;
      adj = shadow_cfg.frame_length_adj;
      if (chan_pos == 0) frame_rest = BASE_TICKS + adj * ADJ_UNIT;
      if (chans > 0) begin
         limit = shadow_cfg.extended_limits ?
                 (HALF_RANGE * EXTENDED_PERCENT_DEF / 100) * 2 : NOMINAL_RANGE;
         clamped = value;
         if (clamped > limit) clamped = limit;
         if (clamped < -limit) clamped = -limit;
         width = clamped + 2 * int'(center_us);
         frame_rest -= width;
         rest = width - int'(shadow_cfg.stop_width);
         if (rest < 0) rest = 0;
         if (rest > DUR_MAX) rest = DUR_MAX;
         items_due.push_back(make_item(shadow_cfg.stop_width, pulse_lv, rest, !pulse_lv,
                                       KIND_PULSE, 1'b0));
         chan_pos++;
         if (chan_pos < chans) return;
      end
      rest = frame_rest;
      if (rest > DUR_MAX) rest = DUR_MAX;
      if (rest < SYNC_MIN) rest = SYNC_MIN;
      items_due.push_back(make_item(shadow_cfg.stop_width, pulse_lv, rest - TERM_TICKS,
                                    !pulse_lv, KIND_SYNC, 1'b0));
      items_due.push_back(make_item(TERM_TICKS, !pulse_lv, 0, !pulse_lv, KIND_TERM, 1'b1));
      chan_pos = 0;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      error_count++;
   endtask

   task automatic compare_field(string name, int got_v, int want_v);
      if (got_v != want_v)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got_v, want_v));
   endtask

   task automatic check_result();
      result_type got;
      result_type want;
      got.first_duration  = rsp_tdata[14:0];
      got.first_level     = rsp_tdata[15];
      got.second_duration = rsp_tdata[30:16];
      got.second_level    = rsp_tdata[31];
      got.item_kind       = rsp_tuser;
      got.frame_end       = rsp_tlast;
      results_seen++;
      if (got.frame_end) frames_closed++;
      if (items_due.size() == 0) begin
         report_mismatch($sformatf("kind %0d arrived with nothing pending", got.item_kind));
      end else begin
         want = items_due.pop_front();
         compare_field("first_duration", got.first_duration, want.first_duration);
         compare_field("first_level", got.first_level, want.first_level);
         compare_field("second_duration", got.second_duration, want.second_duration);
         compare_field("second_level", got.second_level, want.second_level);
         compare_field("item_kind", got.item_kind, want.item_kind);
         compare_field("frame_end", got.frame_end, want.frame_end);
      end
   endtask

   // result side: check each transaction, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      if (holds_asked != holds_done) begin
         holds_done = holds_asked;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  items_due.size());
         $display("** ppm_frame_encoder_top: FAILED **");
         $finish;
      end
   end

   // one channel transaction, valid stays up for a back-to-back successor
   task automatic send_channel(int value, int center);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, center[11:0], value[15:0]};
      do @(posedge clock); while (!req_tready);
      predict_frame_step(value[15:0], center[11:0]);
      channels_sent++;
   endtask

   // stop offering, let every pending result out, then let the pipeline go quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (items_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [ADDR_W-1:0] addr, logic [WDATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // write every register, encoder must be idle
   task automatic configure(bit en, bit pol, int stop, bit ext, int adj, int count,
                            int first_ch);
      write_reg(REG_ENABLED, en);
      write_reg(REG_POLARITY, pol);
      write_reg(REG_STOP, stop[14:0]);
      write_reg(REG_EXTENDED, ext);
      write_reg(REG_ADJ, {7'd0, adj[7:0]});
      write_reg(REG_COUNT, {9'd0, count[5:0]});
      write_reg(REG_FIRST, {10'd0, first_ch[4:0]});
      csr_we <= 1'b0;
      shadow_cfg.enabled           = en;
      shadow_cfg.polarity          = pol;
      shadow_cfg.stop_width        = stop[14:0];
      shadow_cfg.extended_limits   = ext;
      shadow_cfg.frame_length_adj  = adj[7:0];
      shadow_cfg.channels_in_frame = count[5:0];
      shadow_cfg.first_channel     = first_ch[4:0];
      @(posedge clock);
   endtask

   task automatic random_config();
      int stop;
      int adj;
      int count;
      int first_ch;
      case ($urandom_range(7))
         0: stop = 0;
         1: stop = DUR_MAX;
         2: stop = $urandom_range(DUR_MAX);
         default: stop = $urandom_range(300, 900);
      endcase
      adj = ($urandom_range(3) == 0) ? int'($urandom_range(255)) - 128
                                      : int'($urandom_range(20)) - 10;
      count = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(1, 8);
      first_ch = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(3);
      configure($urandom_range(9) != 0, 1'($urandom_range(1)), stop,
                1'($urandom_range(1)), adj, count, first_ch);
   endtask

   // mostly nominal sticks, some raw 16-bit words and clamp edges
   task automatic send_random_channel();
      int value;
      int center;
      center = $urandom_range(4095);
      case ($urandom_range(9))
         0, 1: value = $urandom_range(65535);
         2: begin
            case ($urandom_range(5))
               0: value = NOMINAL_RANGE;
               1: value = -NOMINAL_RANGE - 1;
               2: value = 1536;
               3: value = -1537;
               4: value = 32767;
               default: value = -32768;
            endcase
         end
         default: begin
            value  = int'($urandom_range(3200)) - 1600;
            center = $urandom_range(1400, 1600);
         end
      endcase
      send_channel(value, center);
   endtask

   // reset register values, one full frame of field extremes
   task automatic test_default_frame();
      send_channel(32767, 4095);
      send_channel(-32768, 0);
      send_channel(1024, 1500);
      send_channel(-1024, 1500);
      send_channel(1025, 1000);
      send_channel(-1025, 2000);
      send_channel(0, 0);
      send_channel(12345, 3000);
      drain();
   endtask

   // extended clamp, both polarities, stop and adjustment extremes, sync clamps
   task automatic test_extended_limits();
      configure(1'b1, 1'b1, 0, 1'b1, 127, 2, 0);
      send_channel(1537, 4095);
      send_channel(-1537, 0);
      drain();
      configure(1'b1, 1'b0, DUR_MAX, 1'b0, -128, 1, 0);
      send_channel(-32768, 0);
      drain();
   endtask

   // empty frame, frame clipped at the channel maximum, count shrunk mid-frame
   task automatic test_frame_shapes();
      configure(1'b1, 1'b0, 600, 1'b0, 0, 0, 0);
      send_channel(500, 1500);
      drain();
      configure(1'b1, 1'b1, 600, 1'b0, 3, 63, 31);
      send_channel(-700, 1500);
      drain();
      configure(1'b1, 1'b0, 400, 1'b0, -2, 6, 0);
      send_channel(100, 1500);
      send_channel(-100, 1500);
      send_channel(900, 1100);
      drain();
      configure(1'b1, 1'b0, 400, 1'b0, -2, 2, 0);
      send_channel(300, 1500);
      drain();
      configure(1'b1, 1'b0, 400, 1'b0, -2, 6, 0);
      send_channel(-300, 1500);
      send_channel(50, 1600);
      drain();
      // no channels left while mid-frame: remainder is not reloaded
      configure(1'b1, 1'b0, 400, 1'b0, -2, 0, 0);
      send_channel(0, 1500);
      drain();
   endtask

   // disabled mid-frame: transactions dropped, frame state kept
   task automatic test_disabled();
      configure(1'b1, 1'b0, 600, 1'b0, 0, 8, 0);
      send_channel(200, 1500);
      drain();
      configure(1'b0, 1'b0, 600, 1'b0, 0, 8, 0);
      send_channel(-200, 1500);
      send_channel(1000, 2500);
      drain();
   endtask

   // random register settings with random channel streams under one idling mix
   task automatic test_random_frames(int quota, int idle_pct, int stall_pct);
      int counted;
      int until_reconfig;
      counted        = 0;
      until_reconfig = 0;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      while (counted < quota) begin
         if (until_reconfig == 0) begin
            drain();
            random_config();
            until_reconfig = $urandom_range(20, 40);
         end
         send_random_channel();
         if (shadow_cfg.enabled) counted++;
         until_reconfig--;
      end
      drain();
   endtask

   // long receiver hold while the sender keeps offering back to back
   task automatic test_backpressure();
      drain();
      configure(1'b1, 1'b1, 600, 1'b0, 0, 4, 0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      holds_asked++;
      repeat (40) send_random_channel();
      drain();
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= REG_ENABLED;
      csr_wdata  <= '0;
      shadow_cfg.enabled           = 1'b1;
      shadow_cfg.polarity          = 1'b0;
      shadow_cfg.stop_width        = STOP_RESET;
      shadow_cfg.extended_limits   = 1'b0;
      shadow_cfg.frame_length_adj  = '0;
      shadow_cfg.channels_in_frame = COUNT_RESET;
      shadow_cfg.first_channel     = '0;
      frame_rest     = BASE_TICKS;
      chan_pos       = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_frame();
      test_extended_limits();
      test_frame_shapes();
      test_disabled();
      test_random_frames(90, 0, 0);
      test_random_frames(90, 88, 0);
      test_random_frames(90, 0, 88);
      test_random_frames(90, 29, 29);
      test_backpressure();

      // final wait is bounded so leftovers are reported rather than timed out
      req_tvalid <= 1'b0;
      for (int i = 0; i < END_WAIT && items_due.size() != 0; i++) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (items_due.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", items_due.size()));

      $display("run covered %0d channel transactions, %0d results, %0d closed frames",
               channels_sent, results_seen, frames_closed);
      $display("settings swept polarity, clamp range, stop width, frame length and channel span");
      if (error_count == 0) begin
         $display("** ppm_frame_encoder_top: PASSED **");
      end else begin
         $display("** ppm_frame_encoder_top: FAILED **");
      end
      $finish;
   end

endmodule
